// ----- rtl/sdff_pkg.sv -----
// Shared constants, types and the controller/datapath interface of the decimal field formatter.
package sdff_pkg;

  localparam int MaxWidth   = 63;
  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = 4 * NumDigits;
  localparam int FieldWidth = 6;
  localparam int DigitCntW  = 4;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    SEL_SPACE,
    SEL_ZERO,
    SEL_MINUS,
    SEL_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      dabble;
    logic      measure;
    logic      emit;
    char_sel_e char_sel;
    logic      last;
    logic      pad_dec;
    logic      dig_dec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic pad_nz;
    logic pad_one;
    logic dig_one;
    logic neg;
    logic left;
    logic zero;
  } ctrl_status_t;

endpackage

// ----- rtl/signed_decimal_field_formatter_core.sv -----
// Top level of the signed decimal field formatter: controller, datapath and checks.
// An accepted value is shifted through the shift-and-add-three BCD converter; the measure
// state then finds the digit count and the dispatch state chooses the first run of characters.
// Characters then appear one per cycle, and busy is low again in the cycle that shows the
// final character. Results cannot be stalled.
// Reset is asynchronous and active low; it returns the block to idle with no strobe.
module signed_decimal_field_formatter_core #(
  parameter int MaxWidth = sdff_pkg::MaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  input  logic [5:0]  field_width_i,
  input  logic        left_justify_i,
  input  logic        zero_pad_i,
  output logic        result_valid_o,
  output logic [7:0]  character_o,
  output logic        last_o
);

  sdff_pkg::ctrl_cmd_t    cmd;
  sdff_pkg::ctrl_status_t status;

  sdff_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  sdff_datapath #(
    .MaxWidth (MaxWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .field_width_i  (field_width_i),
    .left_justify_i (left_justify_i),
    .zero_pad_i     (zero_pad_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .character_o    (character_o),
    .last_o         (last_o),
    .result_valid_o (result_valid_o)
  );

  // An accepted item keeps the block busy while it converts.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // A beat that is not the final one of its field comes while the block is still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("field ended without a final beat");

  // The beat after a final one is never a result, since a new item must first pass through conversion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result beat directly after the final beat");

  // Only a minus, a space or a decimal digit is ever produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (character_o == sdff_pkg::CharMinus) ||
                       (character_o == sdff_pkg::CharSpace) ||
                       ((character_o >= 8'h30) && (character_o <= 8'h39)))
    else $error("illegal character produced");

endmodule

// ----- rtl/sdff_datapath.sv -----
// Datapath: binary-to-BCD conversion, field length, run counters and the character register.
module sdff_datapath #(
  parameter int MaxWidth = sdff_pkg::MaxWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sdff_pkg::ValueWidth-1:0] value_i,
  input  logic [sdff_pkg::FieldWidth-1:0] field_width_i,
  input  logic                          left_justify_i,
  input  logic                          zero_pad_i,
  input  sdff_pkg::ctrl_cmd_t           cmd_i,
  output sdff_pkg::ctrl_status_t        status_o,
  output logic [7:0]                    character_o,
  output logic                          last_o,
  output logic                          result_valid_o
);

  localparam int BcdW = sdff_pkg::BcdWidth;
  localparam int ValW = sdff_pkg::ValueWidth;
  localparam int FldW = sdff_pkg::FieldWidth;
  localparam int DigW = sdff_pkg::DigitCntW;
  localparam logic [FldW-1:0] WidthLimit = FldW'(MaxWidth);

  logic [ValW-1:0] mag_q, mag_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] adj;
  logic            neg_q, left_q, zero_q;
  logic [FldW-1:0] width_q;
  logic [FldW-1:0] pad_cnt_q, pad_cnt_d;
  logic [DigW-1:0] dig_cnt_q, dig_cnt_d;
  logic [4:0]      conv_cnt_q, conv_cnt_d;
  logic [7:0]      char_q, char_d;
  logic            last_q;
  logic            valid_q;
  logic [DigW-1:0] nd;
  logic [DigW-1:0] len;
  logic [5:0]      shamt;

  // Add-three correction on every BCD digit before each shift.
  always_comb begin
    for (int i = 0; i < sdff_pkg::NumDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3) : bcd_q[4*i +: 4];
    end
  end

  // Number of significant digits; zero still prints one digit.
  always_comb begin
    nd = DigW'(1);
    for (int i = 1; i < sdff_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        nd = DigW'(i + 1);
      end
    end
  end

  assign len   = nd + {{(DigW-1){1'b0}}, neg_q};
  assign shamt = {4'(4'd10 - nd), 2'b00};

  always_comb begin
    mag_d      = mag_q;
    bcd_d      = bcd_q;
    conv_cnt_d = conv_cnt_q;
    pad_cnt_d  = pad_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    if (cmd_i.load) begin
      mag_d      = value_i[ValW-1] ? (ValW'(0) - value_i) : value_i;
      bcd_d      = '0;
      conv_cnt_d = '0;
    end else if (cmd_i.dabble) begin
      bcd_d      = {adj[BcdW-2:0], mag_q[ValW-1]};
      mag_d      = {mag_q[ValW-2:0], 1'b0};
      conv_cnt_d = conv_cnt_q + 5'd1;
    end else if (cmd_i.measure) begin
      // Left-align the significant digits so the next one is always the top nibble.
      bcd_d     = bcd_q << shamt;
      dig_cnt_d = nd;
      pad_cnt_d = (width_q > {{(FldW-DigW){1'b0}}, len}) ?
                  (width_q - {{(FldW-DigW){1'b0}}, len}) : '0;
    end else begin
      if (cmd_i.pad_dec) begin
        pad_cnt_d = pad_cnt_q - FldW'(1);
      end
      if (cmd_i.dig_dec) begin
        dig_cnt_d = dig_cnt_q - DigW'(1);
        bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
      end
    end
  end

  always_comb begin
    case (cmd_i.char_sel)
      sdff_pkg::SEL_SPACE: char_d = sdff_pkg::CharSpace;
      sdff_pkg::SEL_ZERO:  char_d = sdff_pkg::CharZero;
      sdff_pkg::SEL_MINUS: char_d = sdff_pkg::CharMinus;
      sdff_pkg::SEL_DIGIT: char_d = sdff_pkg::CharZero + {4'd0, bcd_q[BcdW-1 -: 4]};
      default:             char_d = sdff_pkg::CharSpace;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      conv_cnt_q <= conv_cnt_d;
      valid_q    <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    pad_cnt_q <= pad_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    if (cmd_i.load) begin
      neg_q   <= value_i[ValW-1];
      width_q <= (field_width_i > WidthLimit) ? WidthLimit : field_width_i;
      left_q  <= left_justify_i;
      zero_q  <= zero_pad_i & ~left_justify_i;
    end
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  assign status_o.conv_last = (conv_cnt_q == 5'd31);
  assign status_o.pad_nz    = (pad_cnt_q != '0);
  assign status_o.pad_one   = (pad_cnt_q == FldW'(1));
  assign status_o.dig_one   = (dig_cnt_q == DigW'(1));
  assign status_o.neg       = neg_q;
  assign status_o.left      = left_q;
  assign status_o.zero      = zero_q;

  assign character_o    = char_q;
  assign last_o         = last_q;
  assign result_valid_o = valid_q;

endmodule

// ----- rtl/sdff_controller.sv -----
// Controller: sequences conversion, length measurement and the padding, sign and digit runs.
module sdff_controller (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  sdff_pkg::ctrl_status_t status_i,
  output sdff_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_MEASURE,
    ST_DISPATCH,
    ST_PRE_SPACE,
    ST_SIGN,
    ST_ZEROS,
    ST_DIGITS,
    ST_POST_SPACE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (status_i.conv_last) state_d = ST_MEASURE;
      end
      ST_MEASURE: state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (status_i.left) begin
          state_d = status_i.neg ? ST_SIGN : ST_DIGITS;
        end else if (status_i.zero) begin
          state_d = status_i.neg ? ST_SIGN : (status_i.pad_nz ? ST_ZEROS : ST_DIGITS);
        end else if (status_i.pad_nz) begin
          state_d = ST_PRE_SPACE;
        end else begin
          state_d = status_i.neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_PRE_SPACE: begin
        if (status_i.pad_one) state_d = status_i.neg ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        state_d = (status_i.zero && status_i.pad_nz) ? ST_ZEROS : ST_DIGITS;
      end
      ST_ZEROS: begin
        if (status_i.pad_one) state_d = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (status_i.dig_one) begin
          state_d = (status_i.left && status_i.pad_nz) ? ST_POST_SPACE : ST_IDLE;
        end
      end
      ST_POST_SPACE: begin
        if (status_i.pad_one) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.char_sel = sdff_pkg::SEL_SPACE;
    case (state_q)
      ST_IDLE:    cmd_o.load    = start_i;
      ST_CONV:    cmd_o.dabble  = 1'b1;
      ST_MEASURE: cmd_o.measure = 1'b1;
      ST_PRE_SPACE: begin
        cmd_o.emit    = 1'b1;
        cmd_o.pad_dec = 1'b1;
      end
      ST_SIGN: begin
        cmd_o.emit     = 1'b1;
        cmd_o.char_sel = sdff_pkg::SEL_MINUS;
      end
      ST_ZEROS: begin
        cmd_o.emit     = 1'b1;
        cmd_o.char_sel = sdff_pkg::SEL_ZERO;
        cmd_o.pad_dec  = 1'b1;
      end
      ST_DIGITS: begin
        cmd_o.emit     = 1'b1;
        cmd_o.char_sel = sdff_pkg::SEL_DIGIT;
        cmd_o.dig_dec  = 1'b1;
        // Trailing spaces still follow the digits when left-justified with padding.
        cmd_o.last     = status_i.dig_one && !(status_i.left && status_i.pad_nz);
      end
      ST_POST_SPACE: begin
        cmd_o.emit    = 1'b1;
        cmd_o.pad_dec = 1'b1;
        cmd_o.last    = status_i.pad_one;
      end
      default: cmd_o = cmd_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- tb/sv/signed_decimal_field_formatter_core_tb.sv -----
// Self-checking testbench for the signed decimal field formatter core.
module signed_decimal_field_formatter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [31:0] value_i        = '0;
  logic [5:0]  field_width_i  = '0;
  logic        left_justify_i = 1'b0;
  logic        zero_pad_i     = 1'b0;
  logic        busy;
  logic        result_valid_o;
  logic [7:0]  character_o;
  logic        last_o;

  fmt_char_t expected_chars[$];
  int n_errors = 0;
  int n_fields = 0;
  int n_chars  = 0;
  int n_left   = 0;
  int n_zero   = 0;
  int n_space  = 0;
  int n_neg    = 0;
  int burst_left = 0;
  int long_gap   = 50;
  bit allow_gaps = 1'b1;

  signed_decimal_field_formatter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .field_width_i (field_width_i),
    .left_justify_i(left_justify_i),
    .zero_pad_i    (zero_pad_i),
    .result_valid_o(result_valid_o),
    .character_o   (character_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Builds the printf-style field for one value and queues its characters.
  function automatic void predict_field(logic [31:0] val, logic [5:0] w, logic lj, logic zp);
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic        neg;
    int          eff_w;
    int          len;
    int          pad;
    fmt_char_t   c;
    neg = val[31];
    // Unsigned negation keeps the most negative value exact.
    mag = neg ? (32'd0 - val) : val;
    do begin
      digits.push_front(sdff_pkg::CharZero + 8'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    eff_w = (int'(w) > sdff_pkg::MaxWidth) ? sdff_pkg::MaxWidth : int'(w);
    len   = digits.size() + (neg ? 1 : 0);
    pad   = (eff_w > len) ? eff_w - len : 0;
    if (neg) n_neg++;
    if (lj) begin
      n_left++;
      if (neg) text.push_back(sdff_pkg::CharMinus);
      foreach (digits[i]) text.push_back(digits[i]);
      repeat (pad) text.push_back(sdff_pkg::CharSpace);
    end else if (zp) begin
      n_zero++;
      if (neg) text.push_back(sdff_pkg::CharMinus);
      repeat (pad) text.push_back(sdff_pkg::CharZero);
      foreach (digits[i]) text.push_back(digits[i]);
    end else begin
      n_space++;
      repeat (pad) text.push_back(sdff_pkg::CharSpace);
      if (neg) text.push_back(sdff_pkg::CharMinus);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    foreach (text[i]) begin
      c.ch   = text[i];
      c.last = (i == text.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Offers one beat and holds it until the core takes it, then maybe idles.
  task automatic send_field(logic [31:0] val, logic [5:0] w, logic lj, logic zp);
    int gap;
    start          <= 1'b1;
    value_i        <= val;
    field_width_i  <= w;
    left_justify_i <= lj;
    zero_pad_i     <= zp;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_field(val, w, lj, zp);
    n_fields++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, long_gap) : $urandom_range(0, 3);
      if (allow_gaps && gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_chars.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: begin
        // Decimal length boundaries: powers of ten and one below them.
        v = 32'd1;
        repeat ($urandom_range(0, 9)) v = v * 32'd10;
        v = v - $urandom_range(0, 1);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) v = 32'd0 - v;
    return v;
  endfunction

  function automatic logic [5:0] rand_width();
    if ($urandom_range(0, 99) < 8) return 6'($urandom_range(32, 63));
    return 6'($urandom_range(0, 16));
  endfunction

  task automatic test_directed_cases();
    send_field(32'd0, 6'd0, 1'b0, 1'b0);
    send_field(32'd0, 6'd1, 1'b0, 1'b1);
    send_field(32'hffff_ffff, 6'd0, 1'b0, 1'b0);
    send_field(32'h8000_0000, 6'd0, 1'b0, 1'b0);
    send_field(32'h8000_0000, 6'd11, 1'b0, 1'b1);
    send_field(32'h8000_0000, 6'd20, 1'b0, 1'b1);
    send_field(32'h8000_0000, 6'd20, 1'b1, 1'b0);
    send_field(32'h7fff_ffff, 6'd63, 1'b1, 1'b0);
    send_field(32'h7fff_ffff, 6'd63, 1'b0, 1'b1);
    send_field(32'h7fff_ffff, 6'd63, 1'b0, 1'b0);
    send_field(-32'sd42, 6'd8, 1'b1, 1'b0);
    send_field(-32'sd42, 6'd8, 1'b0, 1'b1);
    send_field(-32'sd42, 6'd8, 1'b0, 1'b0);
    // With both flags the zero flag must be ignored.
    send_field(-32'sd42, 6'd8, 1'b1, 1'b1);
    send_field(32'd12345, 6'd3, 1'b0, 1'b1);
    send_field(32'd999999999, 6'd10, 1'b0, 1'b0);
    send_field(32'd1000000000, 6'd10, 1'b0, 1'b1);
    send_field(-32'sd7, 6'd2, 1'b0, 1'b1);
    send_field(32'd5, 6'd63, 1'b0, 1'b1);
    send_field(-32'sd1, 6'd63, 1'b1, 1'b1);
  endtask

  task automatic test_random_fields(int count);
    for (int i = 0; i < count; i++) begin
      // The middle stretch runs back to back with no sender gaps.
      allow_gaps = !(i >= count / 3 && i < count / 2);
      send_field(rand_value(), rand_width(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
    allow_gaps = 1'b1;
  endtask

  task automatic test_restart_after_drain(int groups);
    for (int g = 0; g < groups; g++) begin
      wait_drained();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      repeat ($urandom_range(1, 5)) begin
        send_field(rand_value(), rand_width(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  always @(posedge clk_i) begin : char_check
    fmt_char_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      n_chars++;
      if (expected_chars.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat: expected none, actual char 8'h%02h last %b",
                 $time, character_o, last_o);
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.ch) begin
          n_errors++;
          $display("%0t: character mismatch: expected 8'h%02h, actual 8'h%02h",
                   $time, want.ch, character_o);
        end
        if (last_o !== want.last) begin
          n_errors++;
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_fields(230);
    test_restart_after_drain(10);
    wait_drained();
    // Any stray beat after the final expected character is still caught here.
    repeat (40) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected characters never arrived", $time, expected_chars.size());
    end
    $display("Covered %0d fields (%0d negative): %0d left-justified,",
             n_fields, n_neg, n_left);
    $display("%0d zero-padded, %0d space-padded; checked %0d characters, %0d mismatches.",
             n_zero, n_space, n_chars, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout after %0t with %0d characters outstanding", $time, expected_chars.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sdff_pkg.sv
rtl/sdff_datapath.sv
rtl/sdff_controller.sv
rtl/signed_decimal_field_formatter_core.sv
tb/sv/signed_decimal_field_formatter_core_tb.sv
